// ===== rtl/gqe_pkg.sv =====
// Package for the error-function quadrature block: widths, rule codes, the
// control structs between modules and the exp(-t) table generator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package gqe_pkg;

    localparam int MAX_STEPS      = 4096;
    localparam int EXP_TABLE_BITS = 10;
    localparam int ROM_SIZE       = 1 << EXP_TABLE_BITS;
    localparam int ROM_W          = 31;

    localparam int TYPE_W      = 3;
    localparam int LIMIT_W     = 27;
    localparam int STEP_SIZE_W = 24;
    localparam int RESULT_W    = 32;
    localparam int STEPS_OUT_W = 13;

    localparam int POS_W      = 29;
    localparam int IDX_SH     = 25 - EXP_TABLE_BITS;
    localparam int RR_W       = 4 + IDX_SH;
    localparam int IP_W       = ROM_W + RR_W + 1;
    localparam int WSUM_W     = 33;
    localparam int PANEL_W    = WSUM_W + STEP_SIZE_W;
    localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);
    localparam int ACC_W      = PANEL_W + STEP_CNT_W;
    localparam int RND_W      = ACC_W + 1;
    localparam int DIV_W      = RND_W - 25;
    localparam int DIV_DIGITS = (DIV_W + 7) / 8;
    localparam int DIV_PAD    = DIV_DIGITS * 8;
    localparam int DIV_CNT_W  = $clog2(DIV_DIGITS + 1);

    localparam logic [30:0] ERF_K = 31'd1211587905;

    localparam logic [TYPE_W-1:0] RULE_LEFT  = 3'd0;
    localparam logic [TYPE_W-1:0] RULE_RIGHT = 3'd1;
    localparam logic [TYPE_W-1:0] RULE_MID   = 3'd2;
    localparam logic [TYPE_W-1:0] RULE_TRAP  = 3'd3;
    localparam logic [TYPE_W-1:0] RULE_SIMP  = 3'd4;

    localparam logic [3:0] DIV_BY_3 = 4'd3;
    localparam logic [3:0] DIV_BY_9 = 4'd9;

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    typedef struct packed {
        logic       start;
        logic [3:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic start;
        logic take;
        logic scale;
    } core_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_sts_t;

    typedef logic [ROM_W-1:0] rom_t [ROM_SIZE];

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    function automatic logic [63:0] exp_frac(input logic [63:0] f);
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] term;
        u    = f >> 4;
        s    = Q62_ONE;
        term = Q62_ONE;
        term = mulq(term, u) / 64'd1;  s = s - term;
        term = mulq(term, u) / 64'd2;  s = s + term;
        term = mulq(term, u) / 64'd3;  s = s - term;
        term = mulq(term, u) / 64'd4;  s = s + term;
        term = mulq(term, u) / 64'd5;  s = s - term;
        term = mulq(term, u) / 64'd6;  s = s + term;
        term = mulq(term, u) / 64'd7;  s = s - term;
        term = mulq(term, u) / 64'd8;  s = s + term;
        term = mulq(term, u) / 64'd9;  s = s - term;
        term = mulq(term, u) / 64'd10; s = s + term;
        term = mulq(term, u) / 64'd11; s = s - term;
        term = mulq(term, u) / 64'd12; s = s + term;
        for (int k = 0; k < 4; k++)
        begin
            s = mulq(s, s);
        end
        return s;
    endfunction

    // Entry i holds exp(-(9*i/ROM_SIZE)^2) in Q1.30, zero once t reaches 22.
    function automatic rom_t build_rom();
        rom_t        tab;
        logic [63:0] einv;
        logic [63:0] num;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] v;
        einv = exp_frac(Q62_ONE);
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            num = 64'd81 * 64'(i) * 64'(i);
            if (num >= (64'd22 << (2 * EXP_TABLE_BITS)))
            begin
                tab[i] = '0;
            end
            else
            begin
                t = num << (56 - 2 * EXP_TABLE_BITS);
                n = t >> 56;
                v = exp_frac((t & ((64'd1 << 56) - 64'd1)) << 6);
                for (int j = 0; j < 22; j++)
                begin
                    if (64'(j) < n)
                    begin
                        v = mulq(v, einv);
                    end
                end
                tab[i] = ROM_W'((v + (64'd1 << 31)) >> 32);
            end
        end
        return tab;
    endfunction

endpackage

// ===== rtl/gqe_if.sv =====
// Channel interfaces of the quadrature block: request, response and the
// configuration write channel. Depends on gqe_pkg.
`timescale 1ns / 1ps

interface gqe_req_if import gqe_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [TYPE_W-1:0]      req_type;
    logic [LIMIT_W-1:0]     upper_limit;
    logic [STEP_SIZE_W-1:0] step_size;

    modport source (output valid, output req_type, output upper_limit,
                    output step_size, input ready);
    modport sink   (input valid, input req_type, input upper_limit,
                    input step_size, output ready);
endinterface

interface gqe_rsp_if import gqe_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [RESULT_W-1:0]    result_value;
    logic [STEPS_OUT_W-1:0] steps_taken;
    logic                   step_limit_hit;

    modport source (output valid, output result_value, output steps_taken,
                    output step_limit_hit, input ready);
    modport sink   (input valid, input result_value, input steps_taken,
                    input step_limit_hit, output ready);
endinterface

interface gqe_cfg_if;
    logic valid;
    logic ready;
    logic scale_to_erf;

    modport source (output valid, output scale_to_erf, input ready);
    modport sink   (input valid, input scale_to_erf, output ready);
endinterface

// ===== rtl/gqe_cdiv.sv =====
// Shared divide-by-constant unit (divisor 3 or 9), eight quotient bits per
// cycle by restoring long division. Depends on gqe_pkg.
`timescale 1ns / 1ps

module gqe_cdiv import gqe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    input  logic [DIV_PAD-1:0] dividend,
    output div_rsp_t           rsp,
    output logic [DIV_PAD-1:0] quotient
);

    logic [DIV_PAD-1:0]   work_reg;
    logic [DIV_PAD-1:0]   work_next;
    logic [3:0]           rem_reg;
    logic [3:0]           rem_next;
    logic [3:0]           dv_reg;
    logic [3:0]           dv_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [3:0]           r;
    logic [4:0]           t;
    logic [7:0]           qb;

    always_comb
    begin
        r  = rem_reg;
        t  = '0;
        qb = '0;
        for (int k = 0; k < 8; k++)
        begin
            t = {r, work_reg[DIV_PAD-1-k]};
            if (t >= {1'b0, dv_reg})
            begin
                qb[7-k] = 1'b1;
                r       = 4'(t - {1'b0, dv_reg});
            end
            else
            begin
                qb[7-k] = 1'b0;
                r       = t[3:0];
            end
        end
    end

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dv_next   = req.divisor;
            cnt_next  = DIV_CNT_W'(DIV_DIGITS);
        end
        else if (cnt_reg != '0)
        begin
            work_next = {work_reg[DIV_PAD-9:0], qb};
            rem_next  = r;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
    end

    assign rsp.busy = (cnt_reg != '0);
    assign rsp.rem  = rem_reg;
    assign quotient = work_reg;

endmodule

// ===== rtl/gqe_core.sv =====
// Sequencer and datapath: panel loop, table lookup with interpolation,
// weighted accumulation, rounding and erf scaling. Depends on gqe_pkg, gqe_cdiv.
`timescale 1ns / 1ps

module gqe_core import gqe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  core_ctl_t              ctl,
    input  logic [TYPE_W-1:0]      req_type,
    input  logic [LIMIT_W-1:0]     upper_limit,
    input  logic [STEP_SIZE_W-1:0] step_size,
    output core_sts_t              sts,
    output logic [RESULT_W-1:0]    result_value,
    output logic [STEPS_OUT_W-1:0] steps_taken,
    output logic                   step_limit_hit
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_CHECK  = 17'h00002,
        S_SAMPLE = 17'h00004,
        S_QSTART = 17'h00008,
        S_QWAIT  = 17'h00010,
        S_ROM    = 17'h00020,
        S_MUL    = 17'h00040,
        S_ISTART = 17'h00080,
        S_IWAIT  = 17'h00100,
        S_FVAL   = 17'h00200,
        S_PMUL   = 17'h00400,
        S_PACC   = 17'h00800,
        S_RSTART = 17'h01000,
        S_RWAIT  = 17'h02000,
        S_SCALE  = 17'h04000,
        S_SAT    = 17'h08000,
        S_DONE   = 17'h10000
    } state_t;

    typedef enum logic [1:0] {
        OFF_ZERO = 2'd0,
        OFF_HALF = 2'd1,
        OFF_FULL = 2'd2
    } off_t;

    localparam rom_t          EXP_ROM = build_rom();
    localparam logic [IP_W-1:0] IP_BIAS = IP_W'(9) << (IDX_SH - 1);

    state_t                    state_reg, state_next;
    logic [TYPE_W-1:0]         rule_reg, rule_next;
    logic [POS_W-1:0]          x2_reg, x2_next;
    logic [STEP_SIZE_W-1:0]    h_reg, h_next;
    logic [POS_W-1:0]          p_reg, p_next;
    logic [STEP_CNT_W-1:0]     steps_reg, steps_next;
    logic                      hit_reg, hit_next;
    logic [1:0]                smp_reg, smp_next;
    logic [POS_W-1:0]          y_reg, y_next;
    logic [EXP_TABLE_BITS-1:0] idx_reg, idx_next;
    logic [RR_W-1:0]           rr_reg, rr_next;
    logic                      oor_reg, oor_next;
    logic                      last_reg, last_next;
    logic [ROM_W-1:0]          a_reg;
    logic [ROM_W-1:0]          b_reg;
    logic [IP_W-1:0]           ip_reg, ip_next;
    logic [WSUM_W-1:0]         wsum_reg, wsum_next;
    logic [PANEL_W-1:0]        panel_reg, panel_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [RESULT_W-1:0]       raw_reg, raw_next;
    logic [63:0]               sc_reg, sc_next;
    logic [RESULT_W-1:0]       res_reg, res_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [DIV_PAD-1:0] div_dividend;
    logic [DIV_PAD-1:0] div_quo;

    off_t               off_sel;
    logic [2:0]         weight;
    logic               smp_last;
    logic [POS_W-1:0]   offset;
    logic [ROM_W-1:0]   diff;
    logic [ROM_W-1:0]   fq;
    logic [ROM_W-1:0]   fv;
    logic [RND_W-1:0]   rnd;
    logic [62:0]        scaled;

    gqe_cdiv u_cdiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .rsp      (div_rsp),
        .quotient (div_quo)
    );

    // Sample plan of each rule: where the sample sits in the panel and its weight.
    always_comb
    begin
        off_sel  = OFF_ZERO;
        weight   = 3'd6;
        smp_last = 1'b1;
        case (rule_reg)
            RULE_LEFT:
            begin
                off_sel = OFF_ZERO;
            end
            RULE_RIGHT:
            begin
                off_sel = OFF_FULL;
            end
            RULE_MID:
            begin
                off_sel = OFF_HALF;
            end
            RULE_TRAP:
            begin
                weight   = 3'd3;
                off_sel  = (smp_reg == 2'd0) ? OFF_ZERO : OFF_FULL;
                smp_last = (smp_reg != 2'd0);
            end
            RULE_SIMP:
            begin
                case (smp_reg)
                    2'd0:
                    begin
                        off_sel  = OFF_ZERO;
                        weight   = 3'd1;
                        smp_last = 1'b0;
                    end
                    2'd1:
                    begin
                        off_sel  = OFF_HALF;
                        weight   = 3'd4;
                        smp_last = 1'b0;
                    end
                    default:
                    begin
                        off_sel  = OFF_FULL;
                        weight   = 3'd1;
                        smp_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                off_sel = OFF_ZERO;
            end
        endcase
    end

    always_comb
    begin
        case (off_sel)
            OFF_HALF: offset = POS_W'(h_reg);
            OFF_FULL: offset = POS_W'({h_reg, 1'b0});
            default:  offset = '0;
        endcase
    end

    assign diff   = (a_reg >= b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign fq     = div_quo[ROM_W-1:0];
    assign fv     = oor_reg ? '0 : ((a_reg >= b_reg) ? (a_reg - fq) : (a_reg + fq));
    assign rnd    = RND_W'(acc_reg) + (RND_W'(3) << 24);
    assign scaled = 63'(raw_reg) * 63'(ERF_K);

    always_comb
    begin
        state_next   = state_reg;
        rule_next    = rule_reg;
        x2_next      = x2_reg;
        h_next       = h_reg;
        p_next       = p_reg;
        steps_next   = steps_reg;
        hit_next     = hit_reg;
        smp_next     = smp_reg;
        y_next       = y_reg;
        idx_next     = idx_reg;
        rr_next      = rr_reg;
        oor_next     = oor_reg;
        last_next    = last_reg;
        ip_next      = ip_reg;
        wsum_next    = wsum_reg;
        panel_next   = panel_reg;
        acc_next     = acc_reg;
        raw_next     = raw_reg;
        sc_next      = sc_reg;
        res_next     = res_reg;
        div_req      = '{start: 1'b0, divisor: DIV_BY_9};
        div_dividend = DIV_PAD'(y_reg >> IDX_SH);
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    rule_next  = req_type;
                    x2_next    = POS_W'({upper_limit, 1'b0});
                    h_next     = step_size;
                    p_next     = '0;
                    steps_next = '0;
                    hit_next   = 1'b0;
                    acc_next   = '0;
                    res_next   = '0;
                    state_next = (req_type > RULE_SIMP) ? S_DONE : S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (p_reg >= x2_reg)
                begin
                    state_next = S_RSTART;
                end
                else if (steps_reg >= STEP_CNT_W'(MAX_STEPS))
                begin
                    hit_next   = 1'b1;
                    state_next = S_RSTART;
                end
                else
                begin
                    smp_next   = '0;
                    wsum_next  = '0;
                    state_next = S_SAMPLE;
                end
            end
            S_SAMPLE:
            begin
                y_next     = p_reg + offset;
                state_next = S_QSTART;
            end
            S_QSTART:
            begin
                div_req.start = 1'b1;
                state_next    = S_QWAIT;
            end
            S_QWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    idx_next   = div_quo[EXP_TABLE_BITS-1:0];
                    oor_next   = (div_quo >= DIV_PAD'(ROM_SIZE));
                    last_next  = (div_quo == DIV_PAD'(ROM_SIZE - 1));
                    rr_next    = {div_rsp.rem, y_reg[IDX_SH-1:0]};
                    state_next = S_ROM;
                end
            end
            S_ROM:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                ip_next    = IP_W'(diff) * IP_W'(rr_reg) + IP_BIAS;
                state_next = S_ISTART;
            end
            S_ISTART:
            begin
                div_req.start = 1'b1;
                div_dividend  = DIV_PAD'(ip_reg >> IDX_SH);
                state_next    = S_IWAIT;
            end
            S_IWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    state_next = S_FVAL;
                end
            end
            S_FVAL:
            begin
                wsum_next = wsum_reg + WSUM_W'(fv) * WSUM_W'(weight);
                if (smp_last)
                begin
                    state_next = S_PMUL;
                end
                else
                begin
                    smp_next   = smp_reg + 1'b1;
                    state_next = S_SAMPLE;
                end
            end
            S_PMUL:
            begin
                panel_next = PANEL_W'(wsum_reg) * PANEL_W'(h_reg);
                state_next = S_PACC;
            end
            S_PACC:
            begin
                acc_next   = acc_reg + ACC_W'(panel_reg);
                p_next     = p_reg + POS_W'({h_reg, 1'b0});
                steps_next = steps_reg + 1'b1;
                state_next = S_CHECK;
            end
            S_RSTART:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = DIV_BY_3;
                div_dividend    = DIV_PAD'(rnd >> 25);
                state_next      = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!div_rsp.busy)
                begin
                    raw_next   = (|div_quo[DIV_PAD-1:RESULT_W]) ? '1 : div_quo[RESULT_W-1:0];
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (ctl.scale)
                begin
                    sc_next    = 64'(scaled) + (64'd1 << 29);
                    state_next = S_SAT;
                end
                else
                begin
                    res_next   = raw_reg;
                    state_next = S_DONE;
                end
            end
            S_SAT:
            begin
                res_next   = (|sc_reg[63:62]) ? '1 : sc_reg[61:30];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (ctl.take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rule_reg  <= rule_next;
        x2_reg    <= x2_next;
        h_reg     <= h_next;
        p_reg     <= p_next;
        steps_reg <= steps_next;
        hit_reg   <= hit_next;
        smp_reg   <= smp_next;
        y_reg     <= y_next;
        idx_reg   <= idx_next;
        rr_reg    <= rr_next;
        oor_reg   <= oor_next;
        last_reg  <= last_next;
        ip_reg    <= ip_next;
        wsum_reg  <= wsum_next;
        panel_reg <= panel_next;
        acc_reg   <= acc_next;
        raw_reg   <= raw_next;
        sc_reg    <= sc_next;
        res_reg   <= res_next;
    end

    // Two registered reads of the table; the point past the last entry reads as zero.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ROM)
        begin
            a_reg <= EXP_ROM[idx_reg];
            b_reg <= last_reg ? '0 : EXP_ROM[idx_reg + 1'b1];
        end
    end

    assign sts.idle       = (state_reg == S_IDLE);
    assign sts.done       = (state_reg == S_DONE);
    assign result_value   = res_reg;
    assign steps_taken    = STEPS_OUT_W'(steps_reg);
    assign step_limit_hit = hit_reg;

endmodule

// ===== rtl/gaussian_quadrature_erf.sv =====
// A request runs n panels with s samples per panel (1 for the rectangle rules,
// 2 trapezoid, 3 Simpson); erf scaling adds a rounding and saturation step.
// Each sample uses the shared divide-by-constant unit twice.
// Throughput: one request at a time; a finished word waits in the output register.
// Reset: scale_to_erf returns to 1, the block is idle and no word is pending.
`timescale 1ns / 1ps

module gaussian_quadrature_erf import gqe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gqe_req_if.sink   req,
    gqe_rsp_if.source rsp,
    gqe_cfg_if.sink   cfg
);

    logic                   scale_reg;
    logic                   scale_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [RESULT_W-1:0]    out_value_reg;
    logic [STEPS_OUT_W-1:0] out_steps_reg;
    logic                   out_hit_reg;
    core_ctl_t              ctl;
    core_sts_t              sts;
    logic [RESULT_W-1:0]    core_value;
    logic [STEPS_OUT_W-1:0] core_steps;
    logic                   core_hit;

    gqe_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .req_type       (req.req_type),
        .upper_limit    (req.upper_limit),
        .step_size      (req.step_size),
        .sts            (sts),
        .result_value   (core_value),
        .steps_taken    (core_steps),
        .step_limit_hit (core_hit)
    );

    assign req.ready = sts.idle;
    assign cfg.ready = 1'b1;

    assign ctl.start = req.valid && sts.idle;
    assign ctl.take  = sts.done && (!out_valid_reg || rsp.ready);
    assign ctl.scale = scale_reg;

    assign scale_next     = (cfg.valid) ? cfg.scale_to_erf : scale_reg;
    assign out_valid_next = ctl.take || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scale_reg     <= scale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            out_value_reg <= core_value;
            out_steps_reg <= core_steps;
            out_hit_reg   <= core_hit;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_value   = out_value_reg;
    assign rsp.steps_taken    = out_steps_reg;
    assign rsp.step_limit_hit = out_hit_reg;

endmodule

// ===== rtl/gqe_checker.sv =====
// Port-level checker for the quadrature block and the bind that attaches it.
// Depends on gqe_pkg and the top level gaussian_quadrature_erf.
`timescale 1ns / 1ps

module gqe_checker import gqe_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [RESULT_W-1:0]    out_value,
    input logic [STEPS_OUT_W-1:0] out_steps,
    input logic                   out_hit
);

    // Once a request is taken, the block is not ready in the cycle after.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while previous request still starting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)
                                       && $stable(out_steps) && $stable(out_hit)))
        else $error("stalled response word changed");

    // The step limit flag only appears with the full panel count.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_hit) |-> (out_steps == STEPS_OUT_W'(MAX_STEPS)))
        else $error("step limit flag without full panel count");

endmodule

bind gaussian_quadrature_erf gqe_checker u_gqe_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_value (rsp.result_value),
    .out_steps (rsp.steps_taken),
    .out_hit   (rsp.step_limit_hit)
);
